// ===== rtl/irc_lt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_lt_pkg
// Shared types and codes of the chat line tokenizer.
// ----------------------------------------------------------------------------
package irc_lt_pkg;

  // item_kind codes
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // role codes
  localparam logic [1:0] ROLE_PREFIX   = 2'd0;
  localparam logic [1:0] ROLE_COMMAND  = 2'd1;
  localparam logic [1:0] ROLE_MIDDLE   = 2'd2;
  localparam logic [1:0] ROLE_TRAILING = 2'd3;

  // line_status codes
  localparam logic [1:0] STATUS_DISPATCH = 2'd0;
  localparam logic [1:0] STATUS_NO_CMD   = 2'd1;
  localparam logic [1:0] STATUS_BLANK    = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [5:0] COUNT_MAX = 6'd63;

  // up to three results come from one input byte
  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] out_byte;
    logic [1:0] role;
    logic [4:0] param_index;
    logic       starts_token;
    logic [5:0] param_count;
    logic [1:0] line_status;
    logic       has_prefix;
    logic       last_of_run;
  } item_t;

  localparam item_t ITEM_ZERO = '0;

endpackage

// ===== rtl/irc_lt_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_lt_in_if
// Byte input channel of the line tokenizer.
// ----------------------------------------------------------------------------
interface irc_lt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_last;

  modport source (output valid, output in_byte, output line_last, input ready);
  modport sink   (input valid, input in_byte, input line_last, output ready);
endinterface

// ===== rtl/irc_lt_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_lt_out_if
// Result channel of the line tokenizer: tagged bytes and line summaries.
// ----------------------------------------------------------------------------
interface irc_lt_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] out_byte;
  logic [1:0] role;
  logic [4:0] param_index;
  logic       starts_token;
  logic [5:0] param_count;
  logic [1:0] line_status;
  logic       has_prefix;
  logic       last_of_run;

  modport source (output valid, output item_kind, output out_byte, output role,
                  output param_index, output starts_token, output param_count,
                  output line_status, output has_prefix, output last_of_run,
                  input ready);
  modport sink   (input valid, input item_kind, input out_byte, input role,
                  input param_index, input starts_token, input param_count,
                  input line_status, input has_prefix, input last_of_run,
                  output ready);
endinterface

// ===== rtl/irc_line_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_line_tokenizer_unit
// Byte-serial tagger for chat-protocol lines with a per-line summary.
// ----------------------------------------------------------------------------
// Bytes enter through a one-entry input register; the tagging logic then moves
// one byte per clock, while the buffer holds at most one result, into a
// four-entry result buffer, which drains one result per clock while the output
// is ready. A byte that yields a single result (the usual case) sustains one
// byte per cycle while the output is ready; a byte that yields two or three
// results (line end with its summary, or a released space once the parameter
// limit is reached) holds the input until the buffer has drained back to one
// result or fewer. The first result of a byte passes through the input
// register and then the result buffer before it is presented on the output.
// Bytes that yield nothing (separators, dropped text) still update the parse state.
module irc_line_tokenizer_unit #(
  parameter int MAX_MIDDLE_PARAMS = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  irc_lt_in_if.sink     in_if,
  irc_lt_out_if.source  out_if
);

  // input register
  logic       st_v_r, st_v_nxt;
  logic [7:0] st_byte_r;
  logic       st_last_r;

  // result buffer
  irc_lt_pkg::item_t        buf_r [4];
  irc_lt_pkg::item_t        buf_nxt [4];
  logic [2:0]               cnt_r, cnt_nxt;

  irc_lt_pkg::item_t [2:0]  res;
  logic [1:0]               res_n;
  logic                     room;
  logic                     take;
  logic                     pop;
  logic                     in_acc;
  logic [2:0]               base;

  assign room   = (cnt_r <= 3'd1);
  assign take   = st_v_r && room;
  assign pop    = (cnt_r != 3'd0) && out_if.ready;
  assign in_acc = in_if.valid && in_if.ready;

  assign in_if.ready = !st_v_r || room;
  assign st_v_nxt    = in_acc || (st_v_r && !take);

  irc_lt_core #(
    .MAX_MIDDLE_PARAMS (MAX_MIDDLE_PARAMS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (take),
    .byte_in (st_byte_r),
    .last_in (st_last_r),
    .res     (res),
    .res_n   (res_n)
  );

  always_comb begin
    logic [2:0] k;
    base = cnt_r - {2'b00, pop};
    for (int j = 0; j < 4; j++) begin
      k = 3'(j) - base;
      if (3'(j) < base) begin
        if (pop && j < 3) buf_nxt[j] = buf_r[2'(j + 1)];
        else              buf_nxt[j] = buf_r[j];
      end else if (take && k < {1'b0, res_n}) begin
        buf_nxt[j] = res[k[1:0]];
      end else begin
        buf_nxt[j] = buf_r[j];
      end
    end
    cnt_nxt = base + (take ? {1'b0, res_n} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      st_v_r <= st_v_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_byte_r <= in_if.in_byte;
      st_last_r <= in_if.line_last;
    end
    for (int j = 0; j < 4; j++) begin
      buf_r[j] <= buf_nxt[j];
    end
  end

  assign out_if.valid        = (cnt_r != 3'd0);
  assign out_if.item_kind    = buf_r[0].item_kind;
  assign out_if.out_byte     = buf_r[0].out_byte;
  assign out_if.role         = buf_r[0].role;
  assign out_if.param_index  = buf_r[0].param_index;
  assign out_if.starts_token = buf_r[0].starts_token;
  assign out_if.param_count  = buf_r[0].param_count;
  assign out_if.line_status  = buf_r[0].line_status;
  assign out_if.has_prefix   = buf_r[0].has_prefix;
  assign out_if.last_of_run  = buf_r[0].last_of_run;

endmodule

// ===== rtl/irc_lt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_lt_core
// Per-line parse state and tagging logic; one byte per cycle when fired.
// ----------------------------------------------------------------------------
module irc_lt_core #(
  parameter int MAX_MIDDLE_PARAMS = 31
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [7:0]                 byte_in,
  input  logic                       last_in,
  output irc_lt_pkg::item_t [2:0]    res,
  output logic [1:0]                 res_n
);

  localparam logic [5:0] MAX_MID = 6'(MAX_MIDDLE_PARAMS);

  typedef enum logic [2:0] {
    PH_START, PH_PREFIX, PH_COMMAND, PH_MSGSTART,
    PH_MIDDLE, PH_TRAILING, PH_DROP, PH_BLANK
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [5:0] pcnt_r, pcnt_nxt;
  logic       held_r, held_nxt;
  logic       prefix_r, prefix_nxt;
  logic       cmd_r, cmd_nxt;
  logic       fresh_r, fresh_nxt;
  logic       gap_r, gap_nxt;

  function automatic irc_lt_pkg::item_t mk_byte(input logic [7:0] c, input logic [1:0] role,
                                                input logic [4:0] idx, input logic start);
    irc_lt_pkg::item_t it;
    it              = irc_lt_pkg::ITEM_ZERO;
    it.item_kind    = irc_lt_pkg::KIND_BYTE;
    it.out_byte     = c;
    it.role         = role;
    it.param_index  = idx;
    it.starts_token = start;
    return it;
  endfunction

  function automatic logic [4:0] cur_idx(input logic [5:0] pc);
    logic [5:0] d;
    d = pc - 6'd1;
    return (pc == 6'd0) ? 5'd0 : d[4:0];
  endfunction

  always_comb begin
    irc_lt_pkg::item_t         sum;
    irc_lt_pkg::item_t [2:0]   r;
    logic [1:0]                n;
    logic                      run_mid;
    logic                      skip;

    phase_nxt  = phase_r;
    pcnt_nxt   = pcnt_r;
    held_nxt   = held_r;
    prefix_nxt = prefix_r;
    cmd_nxt    = cmd_r;
    fresh_nxt  = fresh_r;
    gap_nxt    = gap_r;
    r          = '0;
    n          = 2'd0;
    run_mid    = 1'b0;
    skip       = 1'b0;
    sum        = irc_lt_pkg::ITEM_ZERO;

    if (byte_in == irc_lt_pkg::CH_NUL && phase_r != PH_START && phase_r != PH_DROP &&
        phase_r != PH_BLANK) begin
      // early end of line: same as the line-end wrap-up
      if (phase_nxt == PH_MIDDLE && held_nxt && pcnt_nxt >= MAX_MID) begin
        r[n] = mk_byte(irc_lt_pkg::CH_SPACE, irc_lt_pkg::ROLE_MIDDLE, cur_idx(pcnt_nxt),
                       fresh_nxt);
        n = n + 2'd1;
        fresh_nxt = 1'b0;
      end
      if (phase_nxt == PH_MSGSTART) pcnt_nxt = 6'd1;
      held_nxt = 1'b0;
      phase_nxt = PH_DROP;
    end else begin
      case (phase_r)
        PH_START: begin
          if (byte_in == irc_lt_pkg::CH_LF || byte_in == irc_lt_pkg::CH_NUL) begin
            phase_nxt = PH_BLANK;
          end else if (byte_in == irc_lt_pkg::CH_COLON) begin
            prefix_nxt = 1'b1;
            phase_nxt  = PH_PREFIX;
            fresh_nxt  = 1'b1;
          end else if (byte_in == irc_lt_pkg::CH_SPACE) begin
            cmd_nxt   = 1'b1;
            phase_nxt = PH_MSGSTART;
          end else begin
            r[n] = mk_byte(byte_in, irc_lt_pkg::ROLE_COMMAND, 5'd0, 1'b1);
            n = n + 2'd1;
            phase_nxt = PH_COMMAND;
            fresh_nxt = 1'b0;
          end
        end
        PH_PREFIX, PH_COMMAND: begin
          if (byte_in == irc_lt_pkg::CH_SPACE) begin
            cmd_nxt   = 1'b1;
            phase_nxt = (phase_r == PH_PREFIX) ? PH_COMMAND : PH_MSGSTART;
            fresh_nxt = 1'b1;
          end else begin
            r[n] = mk_byte(byte_in, (phase_r == PH_PREFIX) ? irc_lt_pkg::ROLE_PREFIX :
                           irc_lt_pkg::ROLE_COMMAND, 5'd0, fresh_r);
            n = n + 2'd1;
            fresh_nxt = 1'b0;
          end
        end
        PH_MSGSTART: begin
          pcnt_nxt  = 6'd1;
          fresh_nxt = 1'b1;
          if (byte_in == irc_lt_pkg::CH_COLON) begin
            phase_nxt = PH_TRAILING;
          end else begin
            phase_nxt = PH_MIDDLE;
            gap_nxt   = 1'b0;
            held_nxt  = 1'b0;
            run_mid   = 1'b1;
          end
        end
        PH_MIDDLE: begin
          run_mid = 1'b1;
        end
        PH_TRAILING: begin
          r[n] = mk_byte(byte_in, irc_lt_pkg::ROLE_TRAILING, cur_idx(pcnt_r), fresh_r);
          n = n + 2'd1;
          fresh_nxt = 1'b0;
        end
        default: begin
        end
      endcase

      if (run_mid) begin
        // a space is held one byte so that space-colon can be told apart
        if (held_nxt) begin
          held_nxt = 1'b0;
          if (byte_in == irc_lt_pkg::CH_COLON) begin
            skip = 1'b1;
            if (pcnt_nxt >= MAX_MID) begin
              phase_nxt = PH_DROP;
            end else begin
              pcnt_nxt  = pcnt_nxt + 6'd1;
              phase_nxt = PH_TRAILING;
              fresh_nxt = 1'b1;
            end
          end else if (pcnt_nxt >= MAX_MID) begin
            r[n] = mk_byte(irc_lt_pkg::CH_SPACE, irc_lt_pkg::ROLE_MIDDLE, cur_idx(pcnt_nxt),
                           fresh_nxt);
            n = n + 2'd1;
            fresh_nxt = 1'b0;
          end else begin
            gap_nxt = 1'b1;
          end
        end
        if (!skip) begin
          if (byte_in == irc_lt_pkg::CH_SPACE) begin
            held_nxt = 1'b1;
          end else begin
            if (gap_nxt) begin
              r[n] = mk_byte(byte_in, irc_lt_pkg::ROLE_MIDDLE, pcnt_nxt[4:0], 1'b1);
              n = n + 2'd1;
              if (pcnt_nxt < irc_lt_pkg::COUNT_MAX) pcnt_nxt = pcnt_nxt + 6'd1;
              gap_nxt = 1'b0;
            end else begin
              r[n] = mk_byte(byte_in, irc_lt_pkg::ROLE_MIDDLE, cur_idx(pcnt_nxt), fresh_nxt);
              n = n + 2'd1;
            end
            fresh_nxt = 1'b0;
          end
        end
      end
    end

    if (last_in) begin
      if (phase_nxt == PH_MIDDLE && held_nxt && pcnt_nxt >= MAX_MID) begin
        r[n] = mk_byte(irc_lt_pkg::CH_SPACE, irc_lt_pkg::ROLE_MIDDLE, cur_idx(pcnt_nxt),
                       fresh_nxt);
        n = n + 2'd1;
      end
      if (phase_nxt == PH_MSGSTART) pcnt_nxt = 6'd1;
      sum.item_kind = irc_lt_pkg::KIND_SUMMARY;
      if (phase_nxt == PH_BLANK) begin
        sum.line_status = irc_lt_pkg::STATUS_BLANK;
      end else begin
        sum.param_count = pcnt_nxt;
        sum.line_status = cmd_nxt ? irc_lt_pkg::STATUS_DISPATCH : irc_lt_pkg::STATUS_NO_CMD;
        sum.has_prefix  = prefix_nxt;
      end
      r[n] = sum;
      n = n + 2'd1;
      // fresh line
      phase_nxt  = PH_START;
      pcnt_nxt   = 6'd0;
      held_nxt   = 1'b0;
      prefix_nxt = 1'b0;
      cmd_nxt    = 1'b0;
      fresh_nxt  = 1'b0;
      gap_nxt    = 1'b0;
    end

    for (int i = 0; i < irc_lt_pkg::MAX_RESULTS; i++) begin
      r[i].last_of_run = (2'(i) + 2'd1 == n);
    end

    res   = r;
    res_n = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      pcnt_r   <= 6'd0;
      held_r   <= 1'b0;
      prefix_r <= 1'b0;
      cmd_r    <= 1'b0;
      fresh_r  <= 1'b0;
      gap_r    <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      pcnt_r   <= pcnt_nxt;
      held_r   <= held_nxt;
      prefix_r <= prefix_nxt;
      cmd_r    <= cmd_nxt;
      fresh_r  <= fresh_nxt;
      gap_r    <= gap_nxt;
    end
  end

endmodule

// ===== bench/irc_line_tokenizer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_line_tokenizer_unit_tb
// Self-checking bench for the chat line tokenizer. Short hand-written lines
// cover blank lines, early zero termination, missing command, empty fields
// and a prefix/middle/trailing line. Random lines follow, half well formed,
// plus lines around the parameter limit, broken lines, noise and blanks. A
// tag predictor works out the tagged bytes and line summaries of each
// accepted byte and every result transaction is checked against it. Both
// channels idle at random, and the result side holds off once for a long
// stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module irc_line_tokenizer_unit_tb;

  localparam int          LIMIT_PARAMS = 31;
  localparam int unsigned RANDOM_BYTES = 240;
  localparam int unsigned HOLD_AT      = 120;
  localparam int unsigned HOLD_LEN     = 100;

  typedef enum logic [2:0] {
    LN_START, LN_PREFIX, LN_COMMAND, LN_MSGSTART,
    LN_MIDDLE, LN_TRAILING, LN_DROP, LN_BLANK
  } line_phase_t;

  // Tag predictor plus the queue of results still owed by the block
  class line_tag_predictor_t;
    int unsigned       max_mid;
    line_phase_t       phase;
    int unsigned       params;
    bit                held_sp;
    bit                prefix_seen;
    bit                cmd_found;
    bit                ended_early;
    bit                fresh;
    bit                gap_open;
    irc_lt_pkg::item_t run_items[$];
    irc_lt_pkg::item_t expected_tags[$];
    int unsigned       errors;
    int unsigned       checked;

    function new(int unsigned m);
      max_mid = m;
      errors  = 0;
      checked = 0;
      reset_line_state();
    endfunction

    function void reset_line_state();
      phase       = LN_START;
      params      = 0;
      held_sp     = 1'b0;
      prefix_seen = 1'b0;
      cmd_found   = 1'b0;
      ended_early = 1'b0;
      fresh       = 1'b0;
      gap_open    = 1'b0;
    endfunction

    function int unsigned open_index();
      return (params > 0) ? params - 1 : 0;
    endfunction

    function void emit_tagged(logic [7:0] c, logic [1:0] r, int unsigned idx, bit st);
      irc_lt_pkg::item_t it;
      it              = irc_lt_pkg::ITEM_ZERO;
      it.item_kind    = irc_lt_pkg::KIND_BYTE;
      it.out_byte     = c;
      it.role         = r;
      it.param_index  = idx[4:0];
      it.starts_token = st;
      run_items.push_back(it);
    endfunction

    function void end_of_line();
      // a space held at the limit belongs to the last parameter
      if (phase == LN_MIDDLE && held_sp && params >= max_mid) begin
        emit_tagged(irc_lt_pkg::CH_SPACE, irc_lt_pkg::ROLE_MIDDLE, open_index(), fresh);
        fresh = 1'b0;
      end
      if (phase == LN_MSGSTART) params = 1;
      held_sp = 1'b0;
      if (phase != LN_BLANK) phase = LN_DROP;
    endfunction

    function void take_middle(logic [7:0] c);
      if (held_sp) begin
        held_sp = 1'b0;
        if (c == irc_lt_pkg::CH_COLON) begin
          if (params >= max_mid) begin
            phase = LN_DROP;
          end else begin
            params++;
            phase = LN_TRAILING;
            fresh = 1'b1;
          end
          return;
        end
        if (params >= max_mid) begin
          emit_tagged(irc_lt_pkg::CH_SPACE, irc_lt_pkg::ROLE_MIDDLE, open_index(), fresh);
          fresh = 1'b0;
        end else begin
          gap_open = 1'b1;
        end
      end
      if (c == irc_lt_pkg::CH_SPACE) begin
        held_sp = 1'b1;
        return;
      end
      if (gap_open) begin
        emit_tagged(c, irc_lt_pkg::ROLE_MIDDLE, params, 1'b1);
        if (params < 63) params++;
        gap_open = 1'b0;
      end else begin
        emit_tagged(c, irc_lt_pkg::ROLE_MIDDLE, open_index(), fresh);
      end
      fresh = 1'b0;
    endfunction

    function void accept_byte(logic [7:0] c, logic last);
      irc_lt_pkg::item_t sum;
      run_items.delete();
      if (c == irc_lt_pkg::CH_NUL && phase != LN_START && phase != LN_DROP &&
          phase != LN_BLANK) begin
        ended_early = 1'b1;
        end_of_line();
      end else begin
        case (phase)
          LN_START: begin
            if (c == irc_lt_pkg::CH_LF || c == irc_lt_pkg::CH_NUL) begin
              phase = LN_BLANK;
            end else if (c == irc_lt_pkg::CH_COLON) begin
              prefix_seen = 1'b1;
              phase       = LN_PREFIX;
              fresh       = 1'b1;
            end else if (c == irc_lt_pkg::CH_SPACE) begin
              cmd_found = 1'b1;
              phase     = LN_MSGSTART;
            end else begin
              emit_tagged(c, irc_lt_pkg::ROLE_COMMAND, 0, 1'b1);
              phase = LN_COMMAND;
              fresh = 1'b0;
            end
          end
          LN_PREFIX, LN_COMMAND: begin
            if (c == irc_lt_pkg::CH_SPACE) begin
              cmd_found = 1'b1;
              phase     = (phase == LN_PREFIX) ? LN_COMMAND : LN_MSGSTART;
              fresh     = 1'b1;
            end else begin
              emit_tagged(c, (phase == LN_PREFIX) ? irc_lt_pkg::ROLE_PREFIX :
                          irc_lt_pkg::ROLE_COMMAND, 0, fresh);
              fresh = 1'b0;
            end
          end
          LN_MSGSTART: begin
            params = 1;
            fresh  = 1'b1;
            if (c == irc_lt_pkg::CH_COLON) begin
              phase = LN_TRAILING;
            end else begin
              phase    = LN_MIDDLE;
              gap_open = 1'b0;
              held_sp  = 1'b0;
              take_middle(c);
            end
          end
          LN_MIDDLE: take_middle(c);
          LN_TRAILING: begin
            emit_tagged(c, irc_lt_pkg::ROLE_TRAILING, open_index(), fresh);
            fresh = 1'b0;
          end
          default: ;
        endcase
      end

      if (last) begin
        end_of_line();
        sum           = irc_lt_pkg::ITEM_ZERO;
        sum.item_kind = irc_lt_pkg::KIND_SUMMARY;
        if (phase == LN_BLANK) begin
          sum.line_status = irc_lt_pkg::STATUS_BLANK;
        end else begin
          sum.param_count = (params > 63) ? irc_lt_pkg::COUNT_MAX : 6'(params);
          sum.line_status = cmd_found ? irc_lt_pkg::STATUS_DISPATCH :
                            irc_lt_pkg::STATUS_NO_CMD;
          sum.has_prefix  = prefix_seen;
        end
        run_items.push_back(sum);
        reset_line_state();
      end

      if (run_items.size() > 0) run_items[run_items.size() - 1].last_of_run = 1'b1;
      foreach (run_items[i]) expected_tags.push_back(run_items[i]);
    endfunction

    function bit field_ok(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("result %0d: %s expected 0x%0h got 0x%0h", checked, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void match_result(irc_lt_pkg::item_t got);
      irc_lt_pkg::item_t want;
      bit                ok;
      checked++;
      if (expected_tags.size() == 0) begin
        $error("result %0d: unexpected transaction (kind %0d byte 0x%0h)",
               checked, got.item_kind, got.out_byte);
        errors++;
        return;
      end
      want = expected_tags.pop_front();
      ok = 1'b1;
      ok &= field_ok("item_kind",    want.item_kind,    got.item_kind);
      ok &= field_ok("out_byte",     want.out_byte,     got.out_byte);
      ok &= field_ok("role",         want.role,         got.role);
      ok &= field_ok("param_index",  want.param_index,  got.param_index);
      ok &= field_ok("starts_token", want.starts_token, got.starts_token);
      ok &= field_ok("param_count",  want.param_count,  got.param_count);
      ok &= field_ok("line_status",  want.line_status,  got.line_status);
      ok &= field_ok("has_prefix",   want.has_prefix,   got.has_prefix);
      ok &= field_ok("last_of_run",  want.last_of_run,  got.last_of_run);
      if (!ok) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  irc_lt_in_if  in_ch ();
  irc_lt_out_if out_ch ();

  irc_line_tokenizer_unit #(
    .MAX_MIDDLE_PARAMS(LIMIT_PARAMS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  line_tag_predictor_t tags;
  logic [7:0]          line_q[$];
  irc_lt_pkg::item_t   seen_item;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---- line builders ----

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    if (c == irc_lt_pkg::CH_COLON) c = irc_lt_pkg::CH_COLON + 8'd1;
    if ($urandom_range(0, 19) == 0) c = 8'($urandom_range(128, 255));
    if ($urandom_range(0, 39) == 0) c = irc_lt_pkg::CH_LF;
    return c;
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(0, 3))
      0:       return irc_lt_pkg::CH_NUL;
      1:       return irc_lt_pkg::CH_SPACE;
      2:       return irc_lt_pkg::CH_COLON;
      default: return irc_lt_pkg::CH_LF;
    endcase
  endfunction

  function automatic void add_word(int unsigned n);
    repeat (n) line_q.push_back(word_char());
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void make_well_formed();
    int unsigned nmid;
    line_q.delete();
    if ($urandom_range(0, 2) == 0) begin
      line_q.push_back(irc_lt_pkg::CH_COLON);
      add_word($urandom_range(1, 6));
      line_q.push_back(irc_lt_pkg::CH_SPACE);
    end
    add_word(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
    nmid = $urandom_range(0, 4);
    repeat (nmid) begin
      line_q.push_back(irc_lt_pkg::CH_SPACE);
      if ($urandom_range(0, 5) == 0) line_q.push_back(irc_lt_pkg::CH_SPACE);
      add_word($urandom_range(1, 5));
    end
    if ($urandom_range(0, 1) == 0) begin
      line_q.push_back(irc_lt_pkg::CH_SPACE);
      line_q.push_back(irc_lt_pkg::CH_COLON);
      repeat ($urandom_range(0, 8))
        line_q.push_back(($urandom_range(0, 4) == 0) ? special_char() : word_char());
    end else if ($urandom_range(0, 5) == 0) begin
      line_q.push_back(irc_lt_pkg::CH_SPACE);
    end
    if (line_q.size() == 0) add_word(1);
  endfunction

  // middle parameters from just below the limit to past it, assorted endings
  function automatic void make_limit_line();
    line_q.delete();
    add_word(3);
    repeat ($urandom_range(LIMIT_PARAMS - 2, LIMIT_PARAMS + 3)) begin
      line_q.push_back(irc_lt_pkg::CH_SPACE);
      if ($urandom_range(0, 3) == 0) line_q.push_back(irc_lt_pkg::CH_SPACE);
      add_word($urandom_range(1, 2));
    end
    case ($urandom_range(0, 3))
      0: ;
      1: line_q.push_back(irc_lt_pkg::CH_SPACE);
      2: begin
        line_q.push_back(irc_lt_pkg::CH_SPACE);
        line_q.push_back(irc_lt_pkg::CH_COLON);
        add_word($urandom_range(0, 4));
      end
      default: begin
        line_q.push_back(irc_lt_pkg::CH_SPACE);
        line_q.push_back(irc_lt_pkg::CH_SPACE);
      end
    endcase
  endfunction

  function automatic void make_broken();
    make_well_formed();
    line_q[$urandom_range(0, line_q.size() - 1)] = special_char();
  endfunction

  function automatic void make_noise();
    line_q.delete();
    repeat ($urandom_range(1, 8))
      line_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : special_char());
  endfunction

  function automatic void make_blank();
    line_q.delete();
    line_q.push_back(($urandom_range(0, 1) == 0) ? irc_lt_pkg::CH_LF : irc_lt_pkg::CH_NUL);
    repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // ---- byte source ----

  function automatic int unsigned source_gap(bit lazy);
    int unsigned r;
    if (!lazy) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(logic [7:0] c, logic last, bit lazy);
    int unsigned gap;
    gap = source_gap(lazy);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= c;
    in_ch.line_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tags.accept_byte(c, last);
    @(negedge clk);
  endtask

  task automatic send_line();
    bit lazy;
    lazy = ($urandom_range(0, 3) != 0);
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1, lazy);
  endtask

  // ---- result side: random back-pressure plus one long hold-off ----

  initial begin : sink_side
    int unsigned cyc;
    int unsigned stall;
    int unsigned mode_left;
    bit          eager;
    out_ch.ready = 1'b0;
    cyc       = 0;
    stall     = 0;
    mode_left = 0;
    eager     = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == HOLD_AT) stall = HOLD_LEN;
      if (mode_left == 0) begin
        eager     = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(8, 40);
      end
      mode_left--;
      if (stall == 0 && !eager && $urandom_range(0, 49) == 0) stall = $urandom_range(5, 25);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (eager) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_item.item_kind    = out_ch.item_kind;
      seen_item.out_byte     = out_ch.out_byte;
      seen_item.role         = out_ch.role;
      seen_item.param_index  = out_ch.param_index;
      seen_item.starts_token = out_ch.starts_token;
      seen_item.param_count  = out_ch.param_count;
      seen_item.line_status  = out_ch.line_status;
      seen_item.has_prefix   = out_ch.has_prefix;
      seen_item.last_of_run  = out_ch.last_of_run;
      tags.match_result(seen_item);
    end
  end

  initial begin : source_side
    int unsigned random_bytes;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = 8'h00;
    in_ch.line_last = 1'b0;
    rst_n           = 1'b0;
    tags = new(LIMIT_PARAMS);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // blank lines, by newline and by zero
    line_q = {irc_lt_pkg::CH_LF};
    send_line();
    line_q = {irc_lt_pkg::CH_NUL};
    send_line();
    // no space, so no command
    line_q.delete();
    add_text("AB");
    send_line();
    // prefix, command, middle with a top-bit byte, trailing
    line_q.delete();
    add_text(":p C ");
    line_q.push_back(8'hFF);
    add_text(" :t");
    send_line();
    // empty command, empty trailing part
    line_q.delete();
    add_text(" :");
    send_line();
    // message part present but empty
    line_q.delete();
    add_text("C ");
    send_line();
    // newline as data, then a zero cuts the line short
    line_q.delete();
    add_text("C a\n");
    line_q.push_back(irc_lt_pkg::CH_NUL);
    add_text("z");
    send_line();

    random_bytes = 0;
    make_limit_line();
    random_bytes += line_q.size();
    send_line();
    while (random_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 19)) inside
        [0:9]:   make_well_formed();
        10:      make_limit_line();
        [11:14]: make_broken();
        [15:17]: make_noise();
        default: make_blank();
      endcase
      random_bytes += line_q.size();
      send_line();
    end
    in_ch.valid <= 1'b0;

    while (tags.expected_tags.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tags.errors == 0 && tags.expected_tags.size() == 0) begin
      $display("PASS irc_line_tokenizer_unit");
    end else begin
      if (tags.expected_tags.size() != 0)
        $error("%0d expected results never arrived", tags.expected_tags.size());
      $display("FAIL irc_line_tokenizer_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL irc_line_tokenizer_unit");
    $finish;
  end

endmodule

// ===== irc_line_tokenizer_unit.f =====
rtl/irc_lt_pkg.sv
rtl/irc_lt_in_if.sv
rtl/irc_lt_out_if.sv
rtl/irc_lt_core.sv
rtl/irc_line_tokenizer_unit.sv
bench/irc_line_tokenizer_unit_tb.sv
